@@ rtl/core/sct_pkg.sv @@
// ---------------------------------------------------------------------------
// sct_pkg
// Shared types, token kinds and keyword lookup for the source code tokenizer.
// ---------------------------------------------------------------------------
package sct_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int LINE_BITS_DEF   = 16;

    // Field widths of one token word
    localparam int KIND_W   = 6;
    localparam int ERR_W    = 2;
    localparam int OFS_W    = 20;
    localparam int LINE_W   = 16;
    localparam int TOK_BITS = KIND_W + ERR_W + 4 * OFS_W - OFS_W + LINE_W;
    localparam int TDATA_W  = ((TOK_BITS + 7) / 8) * 8;
    localparam int QDEPTH   = 4;
    localparam int QIDX_W   = $clog2(QDEPTH);
    localparam int MAX_TOK  = 3;

    // Token kinds
    localparam logic [KIND_W-1:0] K_ERROR  = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd1;
    localparam logic [KIND_W-1:0] K_AND    = 6'd2;
    localparam logic [KIND_W-1:0] K_CLASS  = 6'd3;
    localparam logic [KIND_W-1:0] K_CASE   = 6'd4;
    localparam logic [KIND_W-1:0] K_DEFLT  = 6'd5;
    localparam logic [KIND_W-1:0] K_ELSE   = 6'd6;
    localparam logic [KIND_W-1:0] K_IF     = 6'd7;
    localparam logic [KIND_W-1:0] K_INFO   = 6'd8;
    localparam logic [KIND_W-1:0] K_FALSE  = 6'd9;
    localparam logic [KIND_W-1:0] K_FOR    = 6'd10;
    localparam logic [KIND_W-1:0] K_FUNC   = 6'd11;
    localparam logic [KIND_W-1:0] K_THIS   = 6'd12;
    localparam logic [KIND_W-1:0] K_TRUE   = 6'd13;
    localparam logic [KIND_W-1:0] K_NIL    = 6'd14;
    localparam logic [KIND_W-1:0] K_OR     = 6'd15;
    localparam logic [KIND_W-1:0] K_RETURN = 6'd16;
    localparam logic [KIND_W-1:0] K_SUPER  = 6'd17;
    localparam logic [KIND_W-1:0] K_SWITCH = 6'd18;
    localparam logic [KIND_W-1:0] K_HAVE   = 6'd19;
    localparam logic [KIND_W-1:0] K_WHILE  = 6'd20;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd21;
    localparam logic [KIND_W-1:0] K_STRING = 6'd22;
    localparam logic [KIND_W-1:0] K_END    = 6'd23;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd24;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd25;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd26;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd27;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd28;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd29;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd30;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd31;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd32;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd33;
    localparam logic [KIND_W-1:0] K_PCT    = 6'd34;
    localparam logic [KIND_W-1:0] K_HASH   = 6'd35;
    localparam logic [KIND_W-1:0] K_ARROW  = 6'd36;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd37;
    localparam logic [KIND_W-1:0] K_BANG   = 6'd39;
    localparam logic [KIND_W-1:0] K_ASSIGN = 6'd41;
    localparam logic [KIND_W-1:0] K_COLON  = 6'd43;
    localparam logic [KIND_W-1:0] K_GT     = 6'd45;
    localparam logic [KIND_W-1:0] K_LT     = 6'd47;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CHAR  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNTRM = 2'd2;

    // Input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_SLASH, MODE_COMMENT, MODE_IDENT, MODE_NUMBER,
        MODE_NUMDOT, MODE_FRACTION, MODE_STRING, MODE_OP2
    } mode_t;

    typedef struct packed {
        logic              last;
        logic [OFS_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [OFS_W-1:0]  len;
        logic [OFS_W-1:0]  start;
        logic [ERR_W-1:0]  err;
        logic [KIND_W-1:0] kind;
    } token_t;

    // Tokens raised by one accepted word
    typedef struct packed {
        logic [1:0]              cnt;
        token_t [MAX_TOK-1:0]    tok;
    } emit_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [KIND_W-1:0] op_single(input logic [7:0] c);
        case (c)
            "-":     return K_MINUS;
            "!":     return K_BANG;
            "=":     return K_ASSIGN;
            ":":     return K_COLON;
            ">":     return K_GT;
            default: return K_LT;
        endcase
    endfunction

    // Prefix holds the first byte lowest; unused bytes are zero
    function automatic logic [KIND_W-1:0] kw_kind(input logic [55:0] pfx,
                                                  input logic [3:0] plen);
        logic [55:0] rev;
        for (int i = 0; i < 7; i++) rev[8*(6-i) +: 8] = pfx[8*i +: 8];
        if (plen[3]) return K_IDENT;
        case (rev)
            {"and", 32'd0}:     return K_AND;
            {"class", 16'd0}:   return K_CLASS;
            {"case", 24'd0}:    return K_CASE;
            "default":          return K_DEFLT;
            {"else", 24'd0}:    return K_ELSE;
            {"if", 40'd0}:      return K_IF;
            {"info", 24'd0}:    return K_INFO;
            {"false", 16'd0}:   return K_FALSE;
            {"for", 32'd0}:     return K_FOR;
            {"func", 24'd0}:    return K_FUNC;
            {"this", 24'd0}:    return K_THIS;
            {"true", 24'd0}:    return K_TRUE;
            {"nil", 32'd0}:     return K_NIL;
            {"or", 40'd0}:      return K_OR;
            {"return", 8'd0}:   return K_RETURN;
            {"super", 16'd0}:   return K_SUPER;
            {"switch", 8'd0}:   return K_SWITCH;
            {"have", 24'd0}:    return K_HAVE;
            {"while", 16'd0}:   return K_WHILE;
            default:            return K_IDENT;
        endcase
    endfunction

endpackage

@@ rtl/core/sct_scan.sv @@
// ---------------------------------------------------------------------------
// sct_scan
// Scanner state and token generation: one source word per cycle when in_fire
// is high, up to three tokens raised per word.
// ---------------------------------------------------------------------------
module sct_scan #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           in_cmd,
    input  logic [7:0]     in_ch,
    output sct_pkg::emit_t emit
);
    import sct_pkg::*;

    localparam logic [LINE_BITS-1:0] LMAX = {LINE_BITS{1'b1}};

    mode_t                  mode_reg,   mode_next;
    logic [7:0]             pend_reg,   pend_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [OFFSET_BITS-1:0] coff_reg,   coff_next;
    logic [LINE_BITS-1:0]   line_reg,   line_next;
    logic [OFFSET_BITS-1:0] lbase_reg,  lbase_next;
    logic [LINE_BITS-1:0]   tline_reg,  tline_next;
    logic [OFFSET_BITS-1:0] tcol_reg,   tcol_next;
    logic [55:0]            pfx_reg,    pfx_next;
    logic [3:0]             plen_reg,   plen_next;

    function automatic token_t mk_tok(input logic [KIND_W-1:0] kind,
                                      input logic [ERR_W-1:0] err,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [OFFSET_BITS-1:0] len,
                                      input logic [LINE_BITS-1:0] line,
                                      input logic [OFFSET_BITS-1:0] col,
                                      input logic last);
        token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = OFS_W'(start);
        t.len   = OFS_W'(len);
        t.line  = LINE_W'(line);
        t.col   = OFS_W'(col);
        t.last  = last;
        return t;
    endfunction

    // Next state and tokens for the accepted word
    always_comb begin
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] off1;
        logic [OFFSET_BITS-1:0] offm1;
        logic [7:0]             c;
        logic                   do_start;
        logic [KIND_W-1:0]      k;
        logic [1:0]             n;
        token_t [MAX_TOK-1:0]   tv;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        tstart_next = tstart_reg;
        coff_next   = coff_reg;
        line_next   = line_reg;
        lbase_next  = lbase_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        pfx_next    = pfx_reg;
        plen_next   = plen_reg;
        off   = coff_reg;
        off1  = coff_reg + 1'b1;
        offm1 = coff_reg - 1'b1;
        c     = in_ch;
        do_start = 1'b1;
        k  = K_ERROR;
        n  = 2'd0;
        tv = '0;

        if (in_fire && in_cmd == CMD_CHAR) begin
            // Close or extend the token in progress
            case (mode_reg)
                MODE_SLASH: begin
                    if (c == "/") begin
                        mode_next = MODE_COMMENT;
                        do_start  = 1'b0;
                    end else begin
                        tv[n] = mk_tok(K_SLASH, ERR_NONE, tstart_reg, off - tstart_reg,
                                       tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == "\n") mode_next = MODE_IDLE;
                    do_start = 1'b0;
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (plen_reg < 4'd7) pfx_next[8*plen_reg[2:0] +: 8] = c;
                        if (plen_reg < 4'd8) plen_next = plen_reg + 4'd1;
                        do_start = 1'b0;
                    end else begin
                        tv[n] = mk_tok(kw_kind(pfx_reg, plen_reg), ERR_NONE, tstart_reg,
                                       off - tstart_reg, tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        do_start = 1'b0;
                    end else if (c == ".") begin
                        mode_next = MODE_NUMDOT;
                        do_start  = 1'b0;
                    end else begin
                        tv[n] = mk_tok(K_NUMBER, ERR_NONE, tstart_reg, off - tstart_reg,
                                       tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_NUMDOT: begin
                    if (is_digit(c)) begin
                        mode_next = MODE_FRACTION;
                        do_start  = 1'b0;
                    end else begin
                        // Number stops before the dot; the dot stands alone
                        tv[n] = mk_tok(K_NUMBER, ERR_NONE, tstart_reg, offm1 - tstart_reg,
                                       tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                        tv[n] = mk_tok(K_DOT, ERR_NONE, offm1, OFFSET_BITS'(1),
                                       tline_reg, offm1 - lbase_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_FRACTION: begin
                    if (is_digit(c)) begin
                        do_start = 1'b0;
                    end else begin
                        tv[n] = mk_tok(K_NUMBER, ERR_NONE, tstart_reg, off - tstart_reg,
                                       tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_STRING: begin
                    if (c == "\"") begin
                        tv[n] = mk_tok(K_STRING, ERR_NONE, tstart_reg, off1 - tstart_reg,
                                       tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    do_start = 1'b0;
                end
                MODE_OP2: begin
                    if ((pend_reg == "-" && c == ">") || (pend_reg != "-" && c == "=")) begin
                        tv[n] = mk_tok(op_single(pend_reg) - 6'd1, ERR_NONE, tstart_reg,
                                       off1 - tstart_reg, tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        do_start  = 1'b0;
                    end else begin
                        tv[n] = mk_tok(op_single(pend_reg), ERR_NONE, tstart_reg,
                                       off - tstart_reg, tline_reg, tcol_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
                default: ;
            endcase

            // Open a new token on this byte
            if (do_start) begin
                mode_next = MODE_IDLE;
                if (!(c == " " || c == "\t" || c == "\r" || c == "\n")) begin
                    tstart_next = off;
                    tline_next  = line_reg;
                    tcol_next   = off - lbase_reg;
                    if (is_alpha(c)) begin
                        pfx_next  = {48'd0, c};
                        plen_next = 4'd1;
                        mode_next = MODE_IDENT;
                    end else if (is_digit(c)) begin
                        mode_next = MODE_NUMBER;
                    end else if (c == "/") begin
                        mode_next = MODE_SLASH;
                    end else if (c == "\"") begin
                        mode_next = MODE_STRING;
                    end else if (c == "-" || c == "!" || c == "=" || c == ":" ||
                                 c == ">" || c == "<") begin
                        pend_next = c;
                        mode_next = MODE_OP2;
                    end else begin
                        case (c)
                            ")":     k = K_RPAREN;
                            "(":     k = K_LPAREN;
                            "{":     k = K_LBRACE;
                            "}":     k = K_RBRACE;
                            ";":     k = K_SEMI;
                            ",":     k = K_COMMA;
                            ".":     k = K_DOT;
                            "+":     k = K_PLUS;
                            "*":     k = K_STAR;
                            "%":     k = K_PCT;
                            "#":     k = K_HASH;
                            default: k = K_ERROR;
                        endcase
                        tv[n] = mk_tok(k, (k == K_ERROR) ? ERR_CHAR : ERR_NONE, off,
                                       OFFSET_BITS'(1), line_reg, off - lbase_reg, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end

            // Advance offset and line count
            coff_next = off1;
            if (c == "\n") begin
                if (line_reg != LMAX) line_next = line_reg + 1'b1;
                lbase_next = off1;
            end
        end else if (in_fire) begin
            // Flush the open token, then the end token
            case (mode_reg)
                MODE_SLASH: begin
                    tv[n] = mk_tok(K_SLASH, ERR_NONE, tstart_reg, off - tstart_reg,
                                   tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                end
                MODE_IDENT: begin
                    tv[n] = mk_tok(kw_kind(pfx_reg, plen_reg), ERR_NONE, tstart_reg,
                                   off - tstart_reg, tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                end
                MODE_NUMBER, MODE_FRACTION: begin
                    tv[n] = mk_tok(K_NUMBER, ERR_NONE, tstart_reg, off - tstart_reg,
                                   tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                end
                MODE_NUMDOT: begin
                    tv[n] = mk_tok(K_NUMBER, ERR_NONE, tstart_reg, offm1 - tstart_reg,
                                   tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                    tv[n] = mk_tok(K_DOT, ERR_NONE, offm1, OFFSET_BITS'(1),
                                   tline_reg, offm1 - lbase_reg, 1'b0);
                    n = n + 2'd1;
                end
                MODE_STRING: begin
                    tv[n] = mk_tok(K_ERROR, ERR_UNTRM, tstart_reg, off - tstart_reg,
                                   tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                end
                MODE_OP2: begin
                    tv[n] = mk_tok(op_single(pend_reg), ERR_NONE, tstart_reg,
                                   off - tstart_reg, tline_reg, tcol_reg, 1'b0);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            tv[n] = mk_tok(K_END, ERR_NONE, off, '0, line_reg, off - lbase_reg, 1'b1);
            n = n + 2'd1;

            // Return to the reset state for the next run
            mode_next   = MODE_IDLE;
            pend_next   = '0;
            tstart_next = '0;
            coff_next   = '0;
            line_next   = LINE_BITS'(1);
            lbase_next  = '0;
            tline_next  = LINE_BITS'(1);
            tcol_next   = '0;
            pfx_next    = '0;
            plen_next   = '0;
        end

        emit.cnt = n;
        emit.tok = tv;
    end

    // Hold scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            tstart_reg <= '0;
            coff_reg   <= '0;
            line_reg   <= LINE_BITS'(1);
            lbase_reg  <= '0;
            tline_reg  <= LINE_BITS'(1);
            tcol_reg   <= '0;
            pfx_reg    <= '0;
            plen_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            tstart_reg <= tstart_next;
            coff_reg   <= coff_next;
            line_reg   <= line_next;
            lbase_reg  <= lbase_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            pfx_reg    <= pfx_next;
            plen_reg   <= plen_next;
        end
    end

endmodule

@@ rtl/core/sct_outq.sv @@
// ---------------------------------------------------------------------------
// sct_outq
// Result queue: up to three tokens in a cycle, one word out a cycle on ready.
// ---------------------------------------------------------------------------
module sct_outq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sct_pkg::emit_t                emit,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sct_pkg::token_t               out_tok
);
    import sct_pkg::*;

    token_t             q_reg [QDEPTH];
    logic [QIDX_W-1:0]  rd_reg,  rd_next;
    logic [QIDX_W:0]    cnt_reg, cnt_next;
    logic [QIDX_W-1:0]  wr;
    logic               pop;

    assign out_valid = cnt_reg != '0;
    assign out_tok   = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for the largest burst from one word
    assign room      = cnt_reg <= (QIDX_W + 1)'(QDEPTH - MAX_TOK);
    assign wr        = rd_reg + cnt_reg[QIDX_W-1:0];

    always_comb begin
        rd_next  = rd_reg + QIDX_W'(pop);
        cnt_next = cnt_reg + (QIDX_W + 1)'(emit.cnt) - (QIDX_W + 1)'(pop);
    end

    // Write the burst behind the tail
    always_ff @(posedge aclk) begin
        for (int j = 0; j < QDEPTH; j++) begin
            logic [QIDX_W-1:0] slot;
            slot = QIDX_W'(j) - wr;
            if (slot < QIDX_W'(emit.cnt)) q_reg[j] <= emit.tok[slot[1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/source_code_tokenizer_core.sv @@
// ---------------------------------------------------------------------------
// source_code_tokenizer_core
// Byte-stream lexical scanner producing positioned tokens.
// ---------------------------------------------------------------------------
// One source byte (tuser 0) or an end-of-source marker (tuser 1) is taken per
// cycle. Each word is scanned combinationally and raises up to three tokens
// into a four-entry result queue; s_tready is high while the queue holds at
// most one token, so ordinary text runs at one byte per clock while m_tready
// stays high. A token that needs lookahead is queued as the byte that ends it
// is taken. The end-of-source marker flushes the open token, emits the end
// token with tlast set and returns the scanner to its reset state.
// ---------------------------------------------------------------------------
module source_code_tokenizer_core #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // ch
    input  logic                        s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // kind, error_kind, start_offset, token_length, line_number, column
    output logic [sct_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import sct_pkg::*;

    emit_t  emit;
    token_t tok;
    logic   room;

    sct_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_tvalid && s_tready),
        .in_cmd  (s_tuser),
        .in_ch   (s_tdata),
        .emit    (emit)
    );

    sct_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .emit      (emit),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    assign s_tready = room;
    assign m_tdata  = TDATA_W'({tok.col, tok.line, tok.len, tok.start, tok.err, tok.kind});
    assign m_tlast  = tok.last;

endmodule

@@ rtl/core/sct_checker.sv @@
// ---------------------------------------------------------------------------
// sct_checker
// Port-level checks for the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
module sct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tlast
);
    import sct_pkg::*;

    // Hold a stalled word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // End token carries its kind and zero length
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[5:0] == K_END && m_tdata[47:28] == 20'd0)
        else $error("end token malformed");

    // Error code only on error tokens
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:6] != ERR_NONE |->
            m_tdata[5:0] == K_ERROR && m_tdata[7:6] <= ERR_UNTRM)
        else $error("error code on wrong token");

    // Queue empties on reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind source_code_tokenizer_core sct_checker u_sct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/source_code_tokenizer_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// source_code_tokenizer_core_test
// Streams source text into the tokenizer and checks every token word against
// a scanner predictor kept in the testbench. Directed fragments cover the
// operators, long identifiers, numbers, strings, comments and error bytes;
// random programs with noise follow. Both sides stall at random, and the
// receiver holds off once for a long stretch so that the input stalls.
// ---------------------------------------------------------------------------
module source_code_tokenizer_core_test;
    import sct_pkg::*;

    localparam int LIMIT = 20000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } src_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    src_word_t  src_q[$];
    token_t     token_q[$];
    int         fail_count;
    int         idle_cycles;
    bit         src_done;
    int         tx_gap;
    int         rx_gap;
    int         hold_left;
    bit         hold_done;
    int         rx_count;

    // Predictor state
    mode_t              p_mode;
    logic [7:0]         p_pend;
    logic [OFS_W-1:0]   p_start;
    logic [OFS_W-1:0]   p_off;
    logic [LINE_W-1:0]  p_line;
    logic [OFS_W-1:0]   p_base;
    logic [LINE_W-1:0]  p_tline;
    logic [OFS_W-1:0]   p_tcol;
    logic [55:0]        p_pfx;
    logic [3:0]         p_plen;

    source_code_tokenizer_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [KIND_W-1:0] single_op_kind(logic [7:0] c);
        case (c)
            "-": return K_MINUS;
            "!": return K_BANG;
            "=": return K_ASSIGN;
            ":": return K_COLON;
            ">": return K_GT;
            default: return K_LT;
        endcase
    endfunction

    // Compare the held identifier prefix with each keyword, first byte lowest
    function automatic logic [KIND_W-1:0] word_kind();
        string words[19];
        logic [55:0] packed_w;
        words = '{"and", "class", "case", "default", "else", "if", "info", "false",
                  "for", "func", "this", "true", "nil", "or", "return", "super",
                  "switch", "have", "while"};
        for (int i = 0; i < 19; i++) begin
            packed_w = '0;
            for (int j = 0; j < words[i].len(); j++) packed_w[8*j +: 8] = words[i][j];
            if (p_plen == words[i].len() && packed_w == p_pfx)
                return K_AND + KIND_W'(i);
        end
        return K_IDENT;
    endfunction

    function automatic void push_token(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e,
                                       logic [OFS_W-1:0] s, logic [OFS_W-1:0] l,
                                       logic [LINE_W-1:0] ln, logic [OFS_W-1:0] c,
                                       logic lst);
        token_t t;
        t.kind = k; t.err = e; t.start = s; t.len = l;
        t.line = ln; t.col = c; t.last = lst;
        token_q.push_back(t);
    endfunction

    function automatic void close_token(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e,
                                        logic [OFS_W-1:0] end_ofs);
        push_token(k, e, p_start, end_ofs - p_start, p_tline, p_tcol, 1'b0);
    endfunction

    function automatic void close_number_dot(logic [OFS_W-1:0] dot);
        close_token(K_NUMBER, ERR_NONE, dot);
        push_token(K_DOT, ERR_NONE, dot, OFS_W'(1), p_tline, dot - p_base, 1'b0);
    endfunction

    function automatic void scanner_reset();
        p_mode = MODE_IDLE; p_pend = '0; p_start = '0; p_off = '0;
        p_line = LINE_W'(1); p_base = '0; p_tline = LINE_W'(1); p_tcol = '0;
        p_pfx = '0; p_plen = '0;
    endfunction

    function automatic void open_token(logic [7:0] c, logic [OFS_W-1:0] off);
        logic [KIND_W-1:0] k;
        p_mode = MODE_IDLE;
        if (c == " " || c == "\t" || c == 8'h0d || c == "\n") return;
        p_start = off; p_tline = p_line; p_tcol = off - p_base;
        if (is_letter(c)) begin
            p_pfx = {48'd0, c}; p_plen = 4'd1; p_mode = MODE_IDENT;
            return;
        end
        if (is_num(c)) begin
            p_mode = MODE_NUMBER;
            return;
        end
        case (c)
            "/": begin p_mode = MODE_SLASH; return; end
            "\"": begin p_mode = MODE_STRING; return; end
            "-", "!", "=", ":", ">", "<": begin
                p_pend = c; p_mode = MODE_OP2;
                return;
            end
            ")": k = K_RPAREN;
            "(": k = K_LPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            "+": k = K_PLUS;
            "*": k = K_STAR;
            "%": k = K_PCT;
            "#": k = K_HASH;
            default: begin
                close_token(K_ERROR, ERR_CHAR, off + 1'b1);
                return;
            end
        endcase
        close_token(k, ERR_NONE, off + 1'b1);
    endfunction

    // Close or extend the open token on one source byte, then open a new one
    function automatic void feed_char(logic [7:0] c, logic [OFS_W-1:0] off);
        case (p_mode)
            MODE_SLASH: begin
                if (c == "/") begin p_mode = MODE_COMMENT; return; end
                close_token(K_SLASH, ERR_NONE, off);
            end
            MODE_COMMENT: begin
                if (c == "\n") p_mode = MODE_IDLE;
                return;
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_num(c)) begin
                    if (p_plen < 4'd7) p_pfx[8*p_plen +: 8] = c;
                    if (p_plen < 4'd8) p_plen = p_plen + 4'd1;
                    return;
                end
                close_token(word_kind(), ERR_NONE, off);
            end
            MODE_NUMBER: begin
                if (is_num(c)) return;
                if (c == ".") begin p_mode = MODE_NUMDOT; return; end
                close_token(K_NUMBER, ERR_NONE, off);
            end
            MODE_NUMDOT: begin
                if (is_num(c)) begin p_mode = MODE_FRACTION; return; end
                close_number_dot(off - 1'b1);
            end
            MODE_FRACTION: begin
                if (is_num(c)) return;
                close_token(K_NUMBER, ERR_NONE, off);
            end
            MODE_STRING: begin
                if (c == "\"") begin
                    close_token(K_STRING, ERR_NONE, off + 1'b1);
                    p_mode = MODE_IDLE;
                end
                return;
            end
            MODE_OP2: begin
                if ((p_pend == "-" && c == ">") || (p_pend != "-" && c == "=")) begin
                    close_token(single_op_kind(p_pend) - 6'd1, ERR_NONE, off + 1'b1);
                    p_mode = MODE_IDLE;
                    return;
                end
                close_token(single_op_kind(p_pend), ERR_NONE, off);
            end
            default: ;
        endcase
        open_token(c, off);
    endfunction

    // Advance the scanner by one word and queue the tokens it raises
    function automatic void scan_word(src_word_t w);
        logic [7:0] c;
        logic [OFS_W-1:0] off;
        c = w.ch;
        off = p_off;
        if (w.cmd == CMD_END) begin
            case (p_mode)
                MODE_SLASH: close_token(K_SLASH, ERR_NONE, off);
                MODE_IDENT: close_token(word_kind(), ERR_NONE, off);
                MODE_NUMBER, MODE_FRACTION: close_token(K_NUMBER, ERR_NONE, off);
                MODE_NUMDOT: close_number_dot(off - 1'b1);
                MODE_STRING: close_token(K_ERROR, ERR_UNTRM, off);
                MODE_OP2: close_token(single_op_kind(p_pend), ERR_NONE, off);
                default: ;
            endcase
            push_token(K_END, ERR_NONE, off, '0, p_line, off - p_base, 1'b1);
            scanner_reset();
            return;
        end
        feed_char(c, off);
        // Count the line once the byte has been scanned
        p_off = off + 1'b1;
        if (c == "\n") begin
            if (p_line != '1) p_line = p_line + 1'b1;
            p_base = p_off;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src_q.push_back('{CMD_CHAR, s[i]});
    endtask

    task automatic add_end();
        src_q.push_back('{CMD_END, 8'h00});
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random fragment, mostly from the pieces the scanner knows, else a random byte
    task automatic add_fragment();
        string pieces[];
        string alnum;
        string digits;
        pieces = '{"and", "class", "case", "default", "else", "if", "info", "false",
                   "for", "func", "this", "true", "nil", "or", "return", "super",
                   "switch", "have", "while", "->", "!=", "==", ":=", ">=", "<=",
                   "-", "!", "=", ":", ">", "<", ")", "(", "{", "}", ";", ",", ".",
                   "+", "/", "*", "%", "#", "\n", " ", "\t"};
        alnum = "aZ_q9x";
        digits = "0123456789";
        case ($urandom_range(0, 5))
            0, 1: add_text(pieces[$urandom_range(0, pieces.size() - 1)]);
            2: begin
                // Identifier: a letter first, then letters and digits
                src_q.push_back('{CMD_CHAR, alnum[$urandom_range(0, 3)]});
                repeat ($urandom_range(0, 9))
                    src_q.push_back('{CMD_CHAR, alnum[$urandom_range(0, 5)]});
            end
            3: begin
                repeat ($urandom_range(1, 3))
                    src_q.push_back('{CMD_CHAR, digits[$urandom_range(0, 9)]});
                if ($urandom_range(0, 1)) add_text(".");
                if ($urandom_range(0, 1)) add_text("57");
            end
            4: add_text($urandom_range(0, 1) ? "\"s t\n r\"" : "// note\n");
            default: src_q.push_back('{CMD_CHAR, 8'($urandom)});
        endcase
        if ($urandom_range(0, 2) == 0) add_text(" ");
    endtask

    // Build the stimulus
    initial begin
        fail_count = 0;
        src_done = 1'b0;
        add_text("x1234567z defaults a->b!=c==d:=e>=f<=g- !=:><#%*+,;.(){}");
        add_end();
        add_text("3.5 7. 9.x /* // c\n\"ab\ncd\"");
        src_q.push_back('{CMD_CHAR, 8'h00});
        src_q.push_back('{CMD_CHAR, 8'hff});
        src_q.push_back('{CMD_CHAR, 8'h80});
        add_text("\r7.");
        add_end();
        add_text("\"open");
        add_end();
        add_text("/");
        add_end();
        add_text("<");
        add_end();
        add_end();
        while (src_q.size() < 130) begin
            add_fragment();
            if ($urandom_range(0, 40) == 0) add_end();
        end
        add_end();
        src_done = 1'b1;
    end

    // Reset
    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Drive source words from the pending queue
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        tx_gap = 0;
        scanner_reset();
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                scan_word('{s_tuser, s_tdata});
                void'(src_q.pop_front());
                tx_gap = pick_gap();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= src_q[0].ch;
                    s_tuser <= src_q[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls, with one long hold-off after some tokens have passed
    initial begin
        m_tready = 1'b0;
        rx_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rx_count = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && rx_count == 40) begin
                hold_done <= 1'b1;
                hold_left <= 60;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
            end
        end
    end

    // Check each token word against the oldest prediction
    always @(posedge aclk) begin
        token_t got;
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_count <= rx_count + 1;
            got = token_t'({m_tlast, m_tdata[TOK_BITS-1:0]});
            if (token_q.size() == 0) begin
                report_mismatch("unexpected token, kind", got.kind, 0);
            end else begin
                want = token_q.pop_front();
                if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.err != want.err) report_mismatch("error_kind", got.err, want.err);
                if (got.start != want.start) report_mismatch("start", got.start, want.start);
                if (got.len != want.len) report_mismatch("length", got.len, want.len);
                if (got.line != want.line) report_mismatch("line", got.line, want.line);
                if (got.col != want.col) report_mismatch("column", got.col, want.col);
                if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Finish once all words are in and all tokens are out
    initial begin
        wait (src_done && aresetn);
        wait (src_q.size() == 0 && token_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && token_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
